### hw/rtl/tdp_pkg.sv
`timescale 1ns / 1ps
// Shared types for the trial division prime tester.
// Holds the controller state encoding and the command and status structs.
// No dependencies.
package tdp_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic next_divisor;
        logic write_result;
        logic result_prime;
    } t_dp_cmd;

    typedef struct packed {
        logic value_lt2;
        logic square_gt_value;
        logic div_done;
        logic rem_zero;
    } t_dp_stat;

endpackage

### hw/rtl/tdp_in_if.sv
`timescale 1ns / 1ps
// Request channel carrying one candidate value.
// No dependencies.
interface tdp_in_if #(
    parameter int VALUE_WIDTH = 16
) ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink (input valid, input candidate, output ready);
endinterface

### hw/rtl/tdp_out_if.sv
`timescale 1ns / 1ps
// Result channel carrying the echoed value and the prime flag.
// No dependencies.
interface tdp_out_if #(
    parameter int VALUE_WIDTH = 16
) ();
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] tested_value;
    logic                   is_prime;

    modport source (output valid, output tested_value, output is_prime, input ready);
    modport sink (input valid, input tested_value, input is_prime, output ready);
endinterface

### hw/rtl/tdp_rem.sv
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Uses no package.
module tdp_rem #(
    parameter int VALUE_WIDTH = 16,
    parameter int DIV_WIDTH   = 9
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [DIV_WIDTH-1:0]   i_divisor,
    output logic                   o_done,
    output logic                   o_rem_zero
);
    localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic                   r_busy;
    logic                   r_done;
    logic [CW-1:0]          r_count;
    logic [VALUE_WIDTH-1:0] r_dividend;
    logic [DIV_WIDTH-1:0]   r_rem;
    logic [DIV_WIDTH-1:0]   r_divisor;
    logic [DIV_WIDTH:0]     trial;
    logic [DIV_WIDTH-1:0]   diff;
    logic [DIV_WIDTH-1:0]   n_rem;

    always_comb begin
        trial = {r_rem, r_dividend[VALUE_WIDTH-1]};
        diff  = trial[DIV_WIDTH-1:0] - r_divisor;
        if (trial >= {1'b0, r_divisor}) begin
            n_rem = diff;
        end else begin
            n_rem = trial[DIV_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_count == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_count    <= CW'(VALUE_WIDTH - 1);
            r_dividend <= i_dividend;
            r_divisor  <= i_divisor;
            r_rem      <= '0;
        end else if (r_busy) begin
            r_count    <= r_count - CW'(1);
            r_dividend <= r_dividend << 1;
            r_rem      <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("Remainder unit restarted while busy.");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy && $past(r_busy))
        else $error("Remainder done without a running division.");
endmodule

### hw/rtl/tdp_datapath.sv
`timescale 1ns / 1ps
// Datapath: candidate, trial divisor, running square and result flag.
// Depends on tdp_pkg and tdp_rem.
module tdp_datapath
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_candidate,
    output t_dp_stat               o_stat,
    output logic [VALUE_WIDTH-1:0] o_tested_value,
    output logic                   o_is_prime
);
    localparam int DW = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SW = VALUE_WIDTH + 2;

    logic [VALUE_WIDTH-1:0] r_value;
    logic [DW-1:0]          r_divisor;
    logic [SW-1:0]          r_square;
    logic                   r_is_prime;
    logic                   rem_done;
    logic                   rem_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= DW'(2);
            r_square  <= SW'(4);
        end else if (i_cmd.load) begin
            r_divisor <= DW'(2);
            r_square  <= SW'(4);
        end else if (i_cmd.next_divisor) begin
            r_divisor <= r_divisor + DW'(1);
            r_square  <= r_square + SW'({r_divisor, 1'b0}) + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_candidate;
        end
        if (i_cmd.write_result) begin
            r_is_prime <= i_cmd.result_prime;
        end
    end

    tdp_rem #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .DIV_WIDTH   (DW)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_value),
        .i_divisor  (r_divisor),
        .o_done     (rem_done),
        .o_rem_zero (rem_zero)
    );

    always_comb begin
        o_stat.value_lt2       = (r_value < VALUE_WIDTH'(2));
        o_stat.square_gt_value = (r_square > SW'(r_value));
        o_stat.div_done        = rem_done;
        o_stat.rem_zero        = rem_zero;
    end

    assign o_tested_value = r_value;
    assign o_is_prime     = r_is_prime;

    a_square_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_square == (SW'(r_divisor) * SW'(r_divisor)))
        else $error("Running square lost track of the divisor.");
endmodule

### hw/rtl/tdp_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing the divisor loop and the handshakes.
// Depends on tdp_pkg.
module tdp_ctrl
    import tdp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);
    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.value_lt2 || i_stat.square_gt_value) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (i_stat.div_done) begin
                    n_state = i_stat.rem_zero ? ST_DONE : ST_CHECK;
                end
            end
            ST_DONE: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            ST_CHECK: begin
                if (i_stat.value_lt2) begin
                    o_cmd.write_result = 1'b1;
                    o_cmd.result_prime = 1'b0;
                end else if (i_stat.square_gt_value) begin
                    o_cmd.write_result = 1'b1;
                    o_cmd.result_prime = 1'b1;
                end else begin
                    o_cmd.div_start = 1'b1;
                end
            end
            ST_DIVIDE: begin
                if (i_stat.div_done) begin
                    if (i_stat.rem_zero) begin
                        o_cmd.write_result = 1'b1;
                        o_cmd.result_prime = 1'b0;
                    end else begin
                        o_cmd.next_divisor = 1'b1;
                    end
                end
            end
            ST_DONE: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    a_done_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> ($past(r_state) == ST_DONE || $past(o_cmd.write_result)))
        else $error("Result presented without a recorded verdict.");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("Request taken while a result is pending.");

    a_load_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_CHECK))
        else $error("Loaded request did not start the divisor loop.");
endmodule

### hw/rtl/trial_division_prime_test_top.sv
`timescale 1ns / 1ps
// Top level of the trial division prime tester.
// Depends on tdp_pkg, tdp_in_if, tdp_out_if, tdp_ctrl and tdp_datapath.
//
//   Port     Dir   Modport  Payload
//   i_cand   in    sink     candidate[VALUE_WIDTH-1:0]
//   o_res    out   source   tested_value[VALUE_WIDTH-1:0], is_prime
//
// One request is handled at a time. Each trial divisor runs a full division in the
// bit-serial remainder unit; a prime candidate n is divided by every divisor from 2
// through floor(sqrt(n)) before the result is offered at the output, while a
// composite candidate stops at its smallest factor.
// Reset is synchronous and active low and returns the controller to idle.
// A stalled result holds the output and keeps the next request waiting.
module trial_division_prime_test_top
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tdp_in_if.sink   i_cand,
    tdp_out_if.source o_res
);
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic     in_ready;
    logic     out_valid;

    tdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cand.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    tdp_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_candidate    (i_cand.candidate),
        .o_stat         (stat),
        .o_tested_value (o_res.tested_value),
        .o_is_prime     (o_res.is_prime)
    );

    assign i_cand.ready = in_ready;
    assign o_res.valid  = out_valid;
endmodule

### tb/sv/tb_trial_division_prime_test_top.sv
`timescale 1ns / 1ps
// Testbench for trial_division_prime_test_top: streams candidate values, predicts each
// verdict by its own trial division and checks the echoed value and the prime flag.
// Depends on tdp_in_if, tdp_out_if and trial_division_prime_test_top.
module tb_trial_division_prime_test_top;

    localparam int VALUE_WIDTH  = 16;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 50000;
    localparam int DRAIN_CYCLES = 50;

    typedef logic [VALUE_WIDTH-1:0] t_value;

    typedef struct {
        t_value tested_value;
        logic   is_prime;
    } t_verdict;

    class prime_verdict_book;
        t_verdict pending[$];
        int       errors;

        function new();
            errors = 0;
        endfunction

        function logic trial_divide_is_prime(t_value n);
            longint unsigned v;
            longint unsigned d;
            v = n;
            if (v < 2) begin
                return 1'b0;
            end
            for (d = 2; d * d <= v; d++) begin
                if (v % d == 0) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_candidate(t_value cand);
            t_verdict want;
            want.tested_value = cand;
            want.is_prime     = trial_divide_is_prime(cand);
            pending.push_back(want);
        endfunction

        function void check_verdict(t_value tested_value, logic is_prime);
            t_verdict want;
            if (pending.size() == 0) begin
                $error("result with no request waiting: tested_value=%0d is_prime=%0b",
                       tested_value, is_prime);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (tested_value !== want.tested_value) begin
                $error("tested_value mismatch: expected %0d, actual %0d",
                       want.tested_value, tested_value);
                errors++;
            end
            if (is_prime !== want.is_prime) begin
                $error("is_prime mismatch for %0d: expected %0b, actual %0b",
                       want.tested_value, want.is_prime, is_prime);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tdp_in_if  #(.VALUE_WIDTH(VALUE_WIDTH)) cand_if ();
    tdp_out_if #(.VALUE_WIDTH(VALUE_WIDTH)) res_if ();

    trial_division_prime_test_top #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (cand_if),
        .o_res   (res_if)
    );

    prime_verdict_book book;
    bit                idling_on;
    bit                hold_req;
    int                sink_stall_left;
    int                quiet_cycles;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cand_if.valid && cand_if.ready) begin
                book.note_candidate(cand_if.candidate);
            end
            if (res_if.valid && res_if.ready) begin
                book.check_verdict(res_if.tested_value, res_if.is_prime);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((cand_if.valid && cand_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        res_if.ready    = 1'b0;
        sink_stall_left = 0;
        quiet_cycles    = 0;
        forever begin
            @(negedge i_clk);
            if (sink_stall_left > 0) begin
                sink_stall_left--;
                res_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req        = 1'b0;
                sink_stall_left = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                sink_stall_left = $urandom_range(0, 2);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    function automatic t_value pick_candidate();
        int sel;
        int root;
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            return t_value'($urandom_range(0, 255));
        end
        if (sel < 80) begin
            root = $urandom_range(2, 63);
            return t_value'(root * root + int'($urandom_range(0, 2)) - 1);
        end
        if (sel < 95) begin
            return t_value'($urandom_range(0, 4095));
        end
        return t_value'($urandom());
    endfunction

    task automatic send_candidate(input t_value cand);
        cand_if.valid     <= 1'b1;
        cand_if.candidate <= cand;
        do begin
            @(posedge i_clk);
        end while (!cand_if.ready);
        @(negedge i_clk);
    endtask

    task automatic source_gap(input int cycles);
        cand_if.valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        cand_if.valid <= 1'b0;
        while (book.pending.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        t_value directed_values[$];
        int     n;
        book              = new();
        i_rst_n           = 1'b0;
        cand_if.valid     = 1'b0;
        cand_if.candidate = '0;
        idling_on         = 1'b0;
        hold_req          = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero and one, the smallest primes, prime squares, other composites, large primes and the edges of the range.
        directed_values = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd8,
                            16'd9, 16'd25, 16'd49, 16'd121, 16'd169, 16'd257, 16'd289,
                            16'h5555, 16'hAAAA, 16'd32749, 16'd32768, 16'd65025,
                            16'd65280, 16'd65521, 16'd65534, 16'd65535};
        foreach (directed_values[k]) begin
            send_candidate(directed_values[k]);
        end

        idling_on = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 600) begin
                hold_req = 1'b1;
            end
            if (n == 1200) begin
                wait_for_results();
            end
            if (n == RANDOM_ITEMS - 200) begin
                idling_on = 1'b0;
            end
            if (idling_on && (n < 600 || n > 620) && $urandom_range(0, 5) == 0) begin
                source_gap($urandom_range(1, 3));
            end
            send_candidate(pick_candidate());
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (book.errors == 0 && book.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/tdp_pkg.sv
hw/rtl/tdp_in_if.sv
hw/rtl/tdp_out_if.sv
hw/rtl/tdp_rem.sv
hw/rtl/tdp_datapath.sv
hw/rtl/tdp_ctrl.sv
hw/rtl/trial_division_prime_test_top.sv
tb/sv/tb_trial_division_prime_test_top.sv
